/* hdl/mdm_pkg.sv */
// ---------------------------------------------------------------------------
// mdm_pkg: shared types and constants of the mecanum drive mixer
// Holds the fixed-point widths, the side payload structs that travel
// alongside the root and translation divider chains, and the register map.
// ---------------------------------------------------------------------------
package mdm_pkg;

   // fixed-point widths
   localparam int ROOT_W = 24;   // floor(sqrt((x*x + y*y) << 16))
   localparam int REM_W  = 26;   // square-root partial remainder
   localparam int RAD_W  = 48;   // square-root radicand
   localparam int MAG_W  = 17;   // |x+y|, |y-x|, max of both
   localparam int PROD_W = ROOT_W + MAG_W;
   localparam int DEN_W  = 25;   // normalising denominator D
   localparam int WHL_W  = 26;   // wheel numerator D -/+ w
   localparam int DTY_Q  = 9;    // duty quotient, 0..256
   localparam int DZ_W   = 15;

   // chain lengths
   localparam int SQ_CELLS = ROOT_W;
   localparam int DV_CELLS = ROOT_W;
   localparam int DU_CELLS = DTY_Q;

   // register map
   localparam int  CSR_ADDR_W    = 3;
   localparam logic CSR_DEAD_ZONE = 1'b0;   // register index, paddr[2]
   localparam logic [DZ_W-1:0] DZ_RESET = 15'd8192;

   localparam logic [DEN_W-1:0] ONE_Q22 = 25'd4194304;
   localparam logic [7:0] DUTY_STOP = 8'd128;
   localparam logic [7:0] DUTY_MAX  = 8'd255;

   // side data along the square-root chain
   typedef struct packed {
      logic [MAG_W-1:0] a_mag;
      logic             a_neg;
      logic [MAG_W-1:0] b_mag;
      logic             b_neg;
      logic [MAG_W-1:0] m;
      logic [15:0]      turn;
      logic             dz;
   } sq_side_type;

   // side data along the translation divider chain
   typedef struct packed {
      logic             a_neg;
      logic             b_neg;
      logic             m_zero;
      logic [15:0]      turn;
      logic [DEN_W-1:0] d;
      logic             dz;
   } dv_side_type;

   localparam int SQ_SIDE_W = $bits(sq_side_type);
   localparam int DV_SIDE_W = $bits(dv_side_type);

endpackage

/* hdl/mdm_sqrt_cell.sv */
// ---------------------------------------------------------------------------
// mdm_sqrt_cell: one digit of the square-root chain
// Resolves one root bit per beat from two radicand bits and hands the
// partial remainder, root and side data to the next cell.
// ---------------------------------------------------------------------------
module mdm_sqrt_cell #(
   parameter int SW = mdm_pkg::SQ_SIDE_W
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       up_valid,
   output logic                       up_stall,
   input  logic [mdm_pkg::REM_W-1:0]  up_rem,
   input  logic [mdm_pkg::ROOT_W-1:0] up_root,
   input  logic [mdm_pkg::RAD_W-1:0]  up_rad,
   input  logic [SW-1:0]              up_side,
   output logic                       dn_valid,
   input  logic                       dn_stall,
   output logic [mdm_pkg::REM_W-1:0]  dn_rem,
   output logic [mdm_pkg::ROOT_W-1:0] dn_root,
   output logic [mdm_pkg::RAD_W-1:0]  dn_rad,
   output logic [SW-1:0]              dn_side
);

   logic                       vld_ff;
   logic [mdm_pkg::REM_W-1:0]  rem_ff, rem_in;
   logic [mdm_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [mdm_pkg::RAD_W-1:0]  rad_ff, rad_in;
   logic [SW-1:0]              side_ff;
   logic [mdm_pkg::REM_W+1:0]  cur_w, trial_w, diff_w;
   logic                       ge_w, ready_w;

   // hold while a beat waits downstream
   assign ready_w  = !vld_ff || !dn_stall;
   assign up_stall = !ready_w;

   // bring down two radicand bits and try the next root bit
   always_comb begin
      cur_w   = {up_rem, up_rad[mdm_pkg::RAD_W-1 -: 2]};
      trial_w = {2'b00, up_root, 2'b01};
      diff_w  = cur_w - trial_w;
      ge_w    = cur_w >= trial_w;
      rem_in  = ge_w ? diff_w[mdm_pkg::REM_W-1:0] : cur_w[mdm_pkg::REM_W-1:0];
      root_in = {up_root[mdm_pkg::ROOT_W-2:0], ge_w};
      rad_in  = {up_rad[mdm_pkg::RAD_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (ready_w) begin
         vld_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_w && up_valid) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         rad_ff  <= rad_in;
         side_ff <= up_side;
      end
   end

   assign dn_valid = vld_ff;
   assign dn_rem   = rem_ff;
   assign dn_root  = root_ff;
   assign dn_rad   = rad_ff;
   assign dn_side  = side_ff;

endmodule

/* hdl/mdm_div_cell.sv */
// ---------------------------------------------------------------------------
// mdm_div_cell: one step of a restoring divider chain
// Resolves one quotient bit per beat for every lane against a shared
// divisor, and hands remainders, quotients and side data onward.
// ---------------------------------------------------------------------------
module mdm_div_cell #(
   parameter int LANES = 2,
   parameter int DW    = mdm_pkg::MAG_W,
   parameter int NW    = mdm_pkg::ROOT_W,
   parameter int QW    = mdm_pkg::ROOT_W,
   parameter int SW    = mdm_pkg::DV_SIDE_W
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       up_valid,
   output logic                       up_stall,
   input  logic [DW-1:0]              up_d,
   input  logic [LANES-1:0][DW-1:0]   up_rem,
   input  logic [LANES-1:0][NW-1:0]   up_num,
   input  logic [LANES-1:0][QW-1:0]   up_quo,
   input  logic [SW-1:0]              up_side,
   output logic                       dn_valid,
   input  logic                       dn_stall,
   output logic [DW-1:0]              dn_d,
   output logic [LANES-1:0][DW-1:0]   dn_rem,
   output logic [LANES-1:0][NW-1:0]   dn_num,
   output logic [LANES-1:0][QW-1:0]   dn_quo,
   output logic [SW-1:0]              dn_side
);

   logic                     vld_ff;
   logic [DW-1:0]            d_ff;
   logic [LANES-1:0][DW-1:0] rem_ff, rem_in;
   logic [LANES-1:0][NW-1:0] num_ff, num_in;
   logic [LANES-1:0][QW-1:0] quo_ff, quo_in;
   logic [SW-1:0]            side_ff;
   logic [LANES-1:0][DW:0]   cur_w, diff_w;
   logic [LANES-1:0]         ge_w;
   logic                     ready_w;

   // hold while a beat waits downstream
   assign ready_w  = !vld_ff || !dn_stall;
   assign up_stall = !ready_w;

   // shift in the next numerator bit and subtract where it fits
   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         cur_w[i]  = {up_rem[i], up_num[i][NW-1]};
         diff_w[i] = cur_w[i] - {1'b0, up_d};
         ge_w[i]   = cur_w[i] >= {1'b0, up_d};
         rem_in[i] = ge_w[i] ? diff_w[i][DW-1:0] : cur_w[i][DW-1:0];
         num_in[i] = {up_num[i][NW-2:0], 1'b0};
         quo_in[i] = {up_quo[i][QW-2:0], ge_w[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (ready_w) begin
         vld_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_w && up_valid) begin
         d_ff    <= up_d;
         rem_ff  <= rem_in;
         num_ff  <= num_in;
         quo_ff  <= quo_in;
         side_ff <= up_side;
      end
   end

   assign dn_valid = vld_ff;
   assign dn_d     = d_ff;
   assign dn_rem   = rem_ff;
   assign dn_num   = num_ff;
   assign dn_quo   = quo_ff;
   assign dn_side  = side_ff;

endmodule

/* hdl/mecanum_drive_mixer_core.sv */
// ---------------------------------------------------------------------------
// mecanum_drive_mixer_core: joystick to four-wheel PWM duty mixer
// Mixes sideways, forward and turning commands into four wheel duties
// through a square-root cell chain and two restoring divider chains.
// ---------------------------------------------------------------------------
//  channel   | direction | handshake          | payload
//  req_      | in        | req_valid/stall    | stick_x, stick_y, turn_rate
//  rsp_      | out       | rsp_valid/stall    | four 8-bit duties
//  csr (APB) | in/out    | psel/penable       | dead_zone at byte address 0
//
// One item enters per cycle unless req_stall is high; the path: input stage,
// 24 root cells, product stage, 24 divider cells, wheel stage, 9 duty cells.
// The cell chains set the latency; the last duty cell is the output register.
// Each stage holds on its own stall, so bubbles close up behind a stalled
// result and inputs keep flowing until the chain is full.
// Synchronous reset empties every stage and loads dead_zone with 0.25.
// ---------------------------------------------------------------------------
module mecanum_drive_mixer_core (
   input  logic                           clock,
   input  logic                           reset,
   // command beats
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [15:0]             req_stick_x,
   input  logic signed [15:0]             req_stick_y,
   input  logic signed [15:0]             req_turn_rate,
   // duty beats
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [7:0]                     rsp_duty_front_left,
   output logic [7:0]                     rsp_duty_front_right,
   output logic [7:0]                     rsp_duty_back_left,
   output logic [7:0]                     rsp_duty_back_right,
   // configuration
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [mdm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   localparam int SQ_N = mdm_pkg::SQ_CELLS;
   localparam int DV_N = mdm_pkg::DV_CELLS;
   localparam int DU_N = mdm_pkg::DU_CELLS;

   // ---------------- configuration register ----------------
   logic [mdm_pkg::DZ_W-1:0] dz_ff, dz_in;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == mdm_pkg::CSR_DEAD_ZONE) ?
                   {{(32 - mdm_pkg::DZ_W){1'b0}}, dz_ff} : 32'd0;

   always_comb begin
      dz_in = dz_ff;
      if (psel && penable && pwrite && paddr[2] == mdm_pkg::CSR_DEAD_ZONE) begin
         dz_in = pwdata[mdm_pkg::DZ_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dz_ff <= mdm_pkg::DZ_RESET;
      end else begin
         dz_ff <= dz_in;
      end
   end

   // ---------------- chain boundaries ----------------
   logic [SQ_N:0] sq_vld, sq_stall;
   logic [mdm_pkg::REM_W-1:0]  sq_rem  [SQ_N+1];
   logic [mdm_pkg::ROOT_W-1:0] sq_root [SQ_N+1];
   logic [mdm_pkg::RAD_W-1:0]  sq_rad  [SQ_N+1];
   logic [mdm_pkg::SQ_SIDE_W-1:0] sq_side [SQ_N+1];

   logic [DV_N:0] dv_vld, dv_stall;
   logic [mdm_pkg::MAG_W-1:0]            dv_d    [DV_N+1];
   logic [1:0][mdm_pkg::MAG_W-1:0]       dv_rem  [DV_N+1];
   logic [1:0][mdm_pkg::ROOT_W-1:0]      dv_num  [DV_N+1];
   logic [1:0][mdm_pkg::ROOT_W-1:0]      dv_quo  [DV_N+1];
   logic [mdm_pkg::DV_SIDE_W-1:0]        dv_side [DV_N+1];

   logic [DU_N:0] du_vld, du_stall;
   logic [mdm_pkg::DEN_W-1:0]            du_d    [DU_N+1];
   logic [3:0][mdm_pkg::DEN_W-1:0]       du_rem  [DU_N+1];
   logic [3:0][mdm_pkg::DTY_Q-1:0]       du_num  [DU_N+1];
   logic [3:0][mdm_pkg::DTY_Q-1:0]       du_quo  [DU_N+1];
   logic [0:0]                           du_side [DU_N+1];

   // ---------------- input stage: squares, diagonals, dead zone ----------------
   logic                 s0_vld_ff, s0_ready;
   logic [30:0]          s0_xx_ff, s0_yy_ff, s0_xx_in, s0_yy_in;
   mdm_pkg::sq_side_type s0_side_ff, s0_side_in;
   logic signed [16:0]   a_w, b_w;
   logic signed [31:0]   xx_w, yy_w;
   logic [15:0]          xm_w, ym_w;
   logic [mdm_pkg::MAG_W-1:0] am_w, bm_w;

   assign s0_ready  = !s0_vld_ff || !sq_stall[0];
   assign req_stall = !s0_ready;

   always_comb begin
      a_w  = {req_stick_x[15], req_stick_x} + {req_stick_y[15], req_stick_y};
      b_w  = {req_stick_y[15], req_stick_y} - {req_stick_x[15], req_stick_x};
      am_w = a_w[16] ? 17'(-a_w) : 17'(a_w);
      bm_w = b_w[16] ? 17'(-b_w) : 17'(b_w);
      xm_w = req_stick_x[15] ? 16'(-req_stick_x) : 16'(req_stick_x);
      ym_w = req_stick_y[15] ? 16'(-req_stick_y) : 16'(req_stick_y);
      xx_w = req_stick_x * req_stick_x;
      yy_w = req_stick_y * req_stick_y;
      s0_xx_in = xx_w[30:0];
      s0_yy_in = yy_w[30:0];
      s0_side_in.a_mag = am_w;
      s0_side_in.a_neg = a_w[16];
      s0_side_in.b_mag = bm_w;
      s0_side_in.b_neg = b_w[16];
      s0_side_in.m     = (am_w > bm_w) ? am_w : bm_w;
      s0_side_in.turn  = req_turn_rate;
      s0_side_in.dz    = (xm_w < {1'b0, dz_ff}) && (ym_w < {1'b0, dz_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
      end else if (s0_ready) begin
         s0_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_ready && req_valid) begin
         s0_xx_ff   <= s0_xx_in;
         s0_yy_ff   <= s0_yy_in;
         s0_side_ff <= s0_side_in;
      end
   end

   // feed the root chain with (x*x + y*y) << 16
   assign sq_vld[0]  = s0_vld_ff;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_rad[0]  = {32'({1'b0, s0_xx_ff}) + 32'({1'b0, s0_yy_ff}), 16'd0};
   assign sq_side[0] = s0_side_ff;

   // ---------------- square-root chain ----------------
   for (genvar k = 0; k < SQ_N; k++) begin : g_sq
      mdm_sqrt_cell #(.SW(mdm_pkg::SQ_SIDE_W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (sq_vld[k]),
         .up_stall (sq_stall[k]),
         .up_rem   (sq_rem[k]),
         .up_root  (sq_root[k]),
         .up_rad   (sq_rad[k]),
         .up_side  (sq_side[k]),
         .dn_valid (sq_vld[k+1]),
         .dn_stall (sq_stall[k+1]),
         .dn_rem   (sq_rem[k+1]),
         .dn_root  (sq_root[k+1]),
         .dn_rad   (sq_rad[k+1]),
         .dn_side  (sq_side[k+1])
      );
   end

   // ---------------- product stage: r*|A|, r*|B|, denominator ----------------
   logic                        sp_vld_ff, sp_ready;
   logic [mdm_pkg::PROD_W-1:0]  sp_na_ff, sp_nb_ff, sp_na_in, sp_nb_in;
   logic [mdm_pkg::MAG_W-1:0]   sp_m_ff;
   mdm_pkg::dv_side_type        sp_side_ff, sp_side_in;
   mdm_pkg::sq_side_type        sq_out_w;
   logic [15:0]                 tm_w;
   logic [mdm_pkg::DEN_W-1:0]   s_w;

   assign sp_ready       = !sp_vld_ff || !dv_stall[0];
   assign sq_stall[SQ_N] = !sp_ready;

   always_comb begin
      sq_out_w = sq_side[SQ_N];
      tm_w     = sq_out_w.turn[15] ? 16'(-sq_out_w.turn) : sq_out_w.turn;
      s_w      = 25'(sq_root[SQ_N]) + 25'({tm_w, 8'd0});
      sp_na_in = sq_root[SQ_N] * sq_out_w.a_mag;
      sp_nb_in = sq_root[SQ_N] * sq_out_w.b_mag;
      sp_side_in.a_neg  = sq_out_w.a_neg;
      sp_side_in.b_neg  = sq_out_w.b_neg;
      sp_side_in.m_zero = (sq_out_w.m == '0);
      sp_side_in.turn   = sq_out_w.turn;
      sp_side_in.d      = (s_w > mdm_pkg::ONE_Q22) ? s_w : mdm_pkg::ONE_Q22;
      sp_side_in.dz     = sq_out_w.dz;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_vld_ff <= 1'b0;
      end else if (sp_ready) begin
         sp_vld_ff <= sq_vld[SQ_N];
      end
   end

   always_ff @(posedge clock) begin
      if (sp_ready && sq_vld[SQ_N]) begin
         sp_na_ff   <= sp_na_in;
         sp_nb_ff   <= sp_nb_in;
         sp_m_ff    <= sq_out_w.m;
         sp_side_ff <= sp_side_in;
      end
   end

   // quotient fits the root width, so the top bits seed the remainder
   assign dv_vld[0]    = sp_vld_ff;
   assign dv_d[0]      = sp_m_ff;
   assign dv_rem[0][0] = sp_na_ff[mdm_pkg::PROD_W-1 -: mdm_pkg::MAG_W];
   assign dv_rem[0][1] = sp_nb_ff[mdm_pkg::PROD_W-1 -: mdm_pkg::MAG_W];
   assign dv_num[0][0] = sp_na_ff[mdm_pkg::ROOT_W-1:0];
   assign dv_num[0][1] = sp_nb_ff[mdm_pkg::ROOT_W-1:0];
   assign dv_quo[0]    = '0;
   assign dv_side[0]   = sp_side_ff;

   // ---------------- translation divider chain ----------------
   for (genvar k = 0; k < DV_N; k++) begin : g_dv
      mdm_div_cell #(
         .LANES (2),
         .DW    (mdm_pkg::MAG_W),
         .NW    (mdm_pkg::ROOT_W),
         .QW    (mdm_pkg::ROOT_W),
         .SW    (mdm_pkg::DV_SIDE_W)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (dv_vld[k]),
         .up_stall (dv_stall[k]),
         .up_d     (dv_d[k]),
         .up_rem   (dv_rem[k]),
         .up_num   (dv_num[k]),
         .up_quo   (dv_quo[k]),
         .up_side  (dv_side[k]),
         .dn_valid (dv_vld[k+1]),
         .dn_stall (dv_stall[k+1]),
         .dn_d     (dv_d[k+1]),
         .dn_rem   (dv_rem[k+1]),
         .dn_num   (dv_num[k+1]),
         .dn_quo   (dv_quo[k+1]),
         .dn_side  (dv_side[k+1])
      );
   end

   // ---------------- wheel stage: mix and form D -/+ w ----------------
   logic                            sw_vld_ff, sw_ready;
   logic [3:0][mdm_pkg::WHL_W-1:0]  sw_u_ff, sw_u_in;
   logic [mdm_pkg::DEN_W-1:0]       sw_d_ff;
   logic                            sw_dz_ff;
   mdm_pkg::dv_side_type            dv_out_w;
   logic [mdm_pkg::WHL_W-1:0]       pa_w, pb_w, tw_w, d26_w;

   assign sw_ready       = !sw_vld_ff || !du_stall[0];
   assign dv_stall[DV_N] = !sw_ready;

   always_comb begin
      dv_out_w = dv_side[DV_N];
      pa_w = dv_out_w.a_neg ? 26'(-{2'b00, dv_quo[DV_N][0]}) : 26'({2'b00, dv_quo[DV_N][0]});
      pb_w = dv_out_w.b_neg ? 26'(-{2'b00, dv_quo[DV_N][1]}) : 26'({2'b00, dv_quo[DV_N][1]});
      if (dv_out_w.m_zero) begin
         pa_w = '0;
         pb_w = '0;
      end
      tw_w  = {{2{dv_out_w.turn[15]}}, dv_out_w.turn, 8'd0};
      d26_w = {1'b0, dv_out_w.d};
      // lanes: front left, front right, back left, back right
      sw_u_in[0] = d26_w - (pa_w + tw_w);
      sw_u_in[1] = d26_w + (pb_w - tw_w);
      sw_u_in[2] = d26_w - (pb_w + tw_w);
      sw_u_in[3] = d26_w + (pa_w - tw_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_vld_ff <= 1'b0;
      end else if (sw_ready) begin
         sw_vld_ff <= dv_vld[DV_N];
      end
   end

   always_ff @(posedge clock) begin
      if (sw_ready && dv_vld[DV_N]) begin
         sw_u_ff  <= sw_u_in;
         sw_d_ff  <= dv_out_w.d;
         sw_dz_ff <= dv_out_w.dz;
      end
   end

   // numerator is (D -/+ w) << 7; quotient stays within 0..256
   assign du_vld[0]  = sw_vld_ff;
   assign du_d[0]    = sw_d_ff;
   assign du_quo[0]  = '0;
   assign du_side[0] = sw_dz_ff;
   for (genvar l = 0; l < 4; l++) begin : g_seed
      assign du_rem[0][l] = {1'b0, sw_u_ff[l][mdm_pkg::WHL_W-1:2]};
      assign du_num[0][l] = {sw_u_ff[l][1:0], 7'd0};
   end

   // ---------------- duty divider chain ----------------
   for (genvar k = 0; k < DU_N; k++) begin : g_du
      mdm_div_cell #(
         .LANES (4),
         .DW    (mdm_pkg::DEN_W),
         .NW    (mdm_pkg::DTY_Q),
         .QW    (mdm_pkg::DTY_Q),
         .SW    (1)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (du_vld[k]),
         .up_stall (du_stall[k]),
         .up_d     (du_d[k]),
         .up_rem   (du_rem[k]),
         .up_num   (du_num[k]),
         .up_quo   (du_quo[k]),
         .up_side  (du_side[k]),
         .dn_valid (du_vld[k+1]),
         .dn_stall (du_stall[k+1]),
         .dn_d     (du_d[k+1]),
         .dn_rem   (du_rem[k+1]),
         .dn_num   (du_num[k+1]),
         .dn_quo   (du_quo[k+1]),
         .dn_side  (du_side[k+1])
      );
   end

   // ---------------- result: saturate, or stop inside the dead zone ----------------
   logic [3:0][7:0] duty_w;

   assign rsp_valid      = du_vld[DU_N];
   assign du_stall[DU_N] = rsp_stall;

   always_comb begin
      for (int l = 0; l < 4; l++) begin
         if (du_side[DU_N][0]) begin
            duty_w[l] = mdm_pkg::DUTY_STOP;
         end else if (du_quo[DU_N][l][mdm_pkg::DTY_Q-1]) begin
            duty_w[l] = mdm_pkg::DUTY_MAX;
         end else begin
            duty_w[l] = du_quo[DU_N][l][7:0];
         end
      end
   end

   assign rsp_duty_front_left  = duty_w[0];
   assign rsp_duty_front_right = duty_w[1];
   assign rsp_duty_back_left   = duty_w[2];
   assign rsp_duty_back_right  = duty_w[3];

endmodule
